// ===== hdl/conv2d_3x3_zero_pad_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 convolution unit
// Immediate-next and same-cycle implication checks on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef CONV2D_3X3_ZERO_PAD_UNIT_ASSERT_SVH
`define CONV2D_3X3_ZERO_PAD_UNIT_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define C3ZP_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define C3ZP_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hdl/c3zp_pkg.sv =====
// ----------------------------------------------------------------------------
// c3zp_pkg
// Shared constants, types and register indexes of the 3x3 convolution unit.
// ----------------------------------------------------------------------------
package c3zp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_BITS  = 11;
  localparam int KROW_BITS = 24;
  localparam int RES_BITS  = 20;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);

  localparam int MQ_DEPTH  = 4;
  localparam int QAW       = $clog2(MQ_DEPTH);
  localparam int QCW       = $clog2(MQ_DEPTH + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OAW       = $clog2(OUT_DEPTH);
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  localparam int W_RESET_EFF = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int H_RESET_EFF = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

  localparam logic [DIM_BITS-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [DIM_BITS-1:0]  HEIGHT_RESET = 11'd1024;
  localparam logic [KROW_BITS-1:0] KTOP_RESET   = 24'h00FF00;
  localparam logic [KROW_BITS-1:0] KMID_RESET   = 24'hFF05FF;
  localparam logic [KROW_BITS-1:0] KBOT_RESET   = 24'h00FF00;

  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_KERNEL_TOP   = 3'd2;
  localparam logic [2:0] CFG_KERNEL_MID   = 3'd3;
  localparam logic [2:0] CFG_KERNEL_BOT   = 3'd4;

  typedef struct packed {
    logic emit;
    logic row_first;
    logic row_last;
    logic col_first;
    logic col_last;
    logic last;
  } c3zp_flags_t;

  typedef struct packed {
    logic [7:0]  upper;
    logic [7:0]  lower;
    logic [7:0]  pixel;
    c3zp_flags_t flags;
  } c3zp_item_t;

  typedef struct packed {
    logic busy;
    logic stage_valid;
  } c3zp_front_status_t;

  typedef enum logic [2:0] {
    RC_IDLE,
    RC_SIZE,
    RC_NPIX,
    RC_CHECK,
    RC_DIV
  } c3zp_rc_state_t;

endpackage

// ===== hdl/c3zp_div.sv =====
// ----------------------------------------------------------------------------
// c3zp_div
// Restoring divider, one quotient bit per cycle, for the stream position.
// ----------------------------------------------------------------------------
module c3zp_div import c3zp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] dividend,
  input  logic [WW-1:0] divisor,
  output logic          done,
  output logic [RW-1:0] quotient,
  output logic [CW-1:0] remainder
);

  localparam int NW = $clog2(PW + 1);

  logic          busy;
  logic [NW-1:0] cnt;
  logic [WW-1:0] rem_r;
  logic [PW-1:0] quo_r;
  logic [WW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[PW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == NW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(PW);
      end else if (busy) begin
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy) begin
      rem_r <= fits ? WW'(trial - {1'b0, divisor}) : WW'(trial);
      quo_r <= {quo_r[PW-2:0], fits};
    end
  end

  assign quotient  = quo_r[RW-1:0];
  assign remainder = rem_r[CW-1:0];

endmodule

// ===== hdl/c3zp_front.sv =====
// ----------------------------------------------------------------------------
// c3zp_front
// Accepts pixels, tracks row and column, runs the line store and classifies
// each item by its border and result flags before it enters the queue.
// ----------------------------------------------------------------------------
module c3zp_front import c3zp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                dim_write,
  input  logic [DIM_BITS-1:0] width_raw,
  input  logic [DIM_BITS-1:0] height_raw,
  input  logic                push,
  input  logic [7:0]          pixel_in,
  output logic                full,
  input  logic [QCW-1:0]      q_count,
  output logic                q_push,
  output c3zp_item_t          q_item,
  output c3zp_front_status_t  status
);

  function automatic logic [WW-1:0] clamp_w(input logic [DIM_BITS-1:0] v);
    if (v == '0) return WW'(1);
    else if (int'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
    else return WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [DIM_BITS-1:0] v);
    if (v == '0) return HW'(1);
    else if (int'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
    else return HW'(v);
  endfunction

  c3zp_rc_state_t state, state_next;

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [PW-1:0]    pos;
  logic [CW-1:0]    pcol;
  logic [RW-1:0]    prow;
  logic [PW-1:0]    prod;
  logic [WW+HW-1:0] npix_full;
  logic             past_end;
  logic             div_start;
  logic             div_done;
  logic [RW-1:0]    div_quo;
  logic [CW-1:0]    div_rem;

  logic        accept;
  logic        pcol_zero;
  logic        at_col_end;
  logic        at_wrap;
  logic [RW-1:0] krow;
  logic [7:0]  px_eff;
  c3zp_flags_t a_flags;

  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] rd_word;
  logic [15:0] cur_word;
  logic [15:0] wr_word;
  logic        b_valid;
  logic [CW-1:0] b_col;
  logic [7:0]  b_px;
  c3zp_flags_t b_flags;
  logic        fwd_valid;
  logic [CW-1:0] fwd_addr;
  logic [15:0] fwd_word;

  assign npix_full = w_eff * h_eff;
  assign past_end  = pos > (prod + PW'(w_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      RC_IDLE:  state_next = RC_IDLE;
      RC_SIZE:  state_next = RC_NPIX;
      RC_NPIX:  state_next = RC_CHECK;
      RC_CHECK: begin
        if (past_end) begin
          state_next = RC_IDLE;
        end else begin
          state_next = RC_DIV;
          div_start  = 1'b1;
        end
      end
      RC_DIV: begin
        if (div_done) begin
          state_next = RC_IDLE;
        end
      end
      default: state_next = RC_IDLE;
    endcase
    if (dim_write) begin
      state_next = RC_SIZE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= WW'(W_RESET_EFF);
      h_eff <= HW'(H_RESET_EFF);
    end else if (state == RC_SIZE) begin
      w_eff <= clamp_w(width_raw);
      h_eff <= clamp_h(height_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (state == RC_NPIX) begin
      prod <= PW'(npix_full);
    end
  end

  c3zp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (pos),
    .divisor   (w_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign status.busy        = (state != RC_IDLE);
  assign status.stage_valid = b_valid;

  assign full   = status.busy ||
                  (({1'b0, q_count} + (QCW+1)'(b_valid)) >= (QCW+1)'(MQ_DEPTH));
  assign accept = push && !full;

  assign pcol_zero  = (pcol == '0);
  assign at_col_end = (WW'(pcol) + WW'(1)) == w_eff;
  assign at_wrap    = (prow == RW'(h_eff) + RW'(1)) && pcol_zero;
  assign krow       = prow - RW'(1) - RW'(pcol_zero);
  assign px_eff     = (prow < RW'(h_eff)) ? pixel_in : 8'd0;

  always_comb begin
    a_flags.emit      = (prow >= RW'(2)) || ((prow == RW'(1)) && !pcol_zero);
    a_flags.row_first = (krow == '0);
    a_flags.row_last  = (krow == RW'(h_eff) - RW'(1));
    a_flags.col_first = pcol_zero ? (w_eff == WW'(1)) : (pcol == CW'(1));
    a_flags.col_last  = pcol_zero;
    a_flags.last      = a_flags.row_last && pcol_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      pcol <= '0;
      prow <= '0;
    end else if ((state == RC_CHECK) && past_end) begin
      pos  <= '0;
      pcol <= '0;
      prow <= '0;
    end else if ((state == RC_DIV) && div_done) begin
      pcol <= div_rem;
      prow <= div_quo;
    end else if (accept) begin
      if (at_wrap) begin
        pos  <= '0;
        pcol <= '0;
        prow <= '0;
      end else begin
        pos <= pos + PW'(1);
        if (at_col_end) begin
          pcol <= '0;
          prow <= prow + RW'(1);
        end else begin
          pcol <= pcol + CW'(1);
        end
      end
    end
  end

  // The line store word holds the pixel two rows back above the one row back.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= line_mem[pcol];
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      line_mem[b_col] <= wr_word;
    end
  end

  assign cur_word = (fwd_valid && (fwd_addr == b_col)) ? fwd_word : rd_word;
  assign wr_word  = {cur_word[7:0], b_px};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      b_valid   <= accept;
      fwd_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col   <= pcol;
      b_px    <= px_eff;
      b_flags <= a_flags;
    end
    fwd_addr <= b_col;
    fwd_word <= wr_word;
  end

  assign q_push       = b_valid;
  assign q_item.upper = cur_word[15:8];
  assign q_item.lower = cur_word[7:0];
  assign q_item.pixel = b_px;
  assign q_item.flags = b_flags;

endmodule

// ===== hdl/c3zp_queue.sv =====
// ----------------------------------------------------------------------------
// c3zp_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module c3zp_queue import c3zp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  c3zp_item_t     push_item,
  input  logic           pop,
  output c3zp_item_t     pop_item,
  output logic           empty,
  output logic [QCW-1:0] count
);

  c3zp_item_t     entries [MQ_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;

  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(MQ_DEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(MQ_DEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

endmodule

// ===== hdl/c3zp_back.sv =====
// ----------------------------------------------------------------------------
// c3zp_back
// Sliding 3x3 window, masked multiply-accumulate pipeline and result queue.
// ----------------------------------------------------------------------------
module c3zp_back import c3zp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [KROW_BITS-1:0] kernel_top,
  input  logic [KROW_BITS-1:0] kernel_mid,
  input  logic [KROW_BITS-1:0] kernel_bot,
  input  logic                 q_empty,
  input  c3zp_item_t           q_item,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [RES_BITS-1:0]  filtered_value,
  output logic                 last_of_image
);

  logic [7:0]  win [3][3];
  logic        s1_valid, s2_valid, s3_valid;
  c3zp_flags_t s1_flags, s2_flags, s3_flags;

  logic signed [16:0] prd_next [3][3];
  logic signed [16:0] prd [3][3];
  logic signed [18:0] row_sum [3];
  logic signed [RES_BITS:0] total;
  logic [KROW_BITS-1:0] krows [3];
  logic [2:0] row_on;
  logic [2:0] col_on;

  logic [RES_BITS-1:0] out_value [OUT_DEPTH];
  logic                out_last  [OUT_DEPTH];
  logic [OAW-1:0]      out_wr;
  logic [OAW-1:0]      out_rd;
  logic [OCW-1:0]      out_count;
  logic [OCW:0]        pending;
  logic                out_push;
  logic                out_pop;

  assign pending = {1'b0, out_count} + (OCW+1)'(s1_valid) + (OCW+1)'(s2_valid) +
                   (OCW+1)'(s3_valid);
  assign q_pop   = !q_empty && (pending < (OCW+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= 8'd0;
        end
      end
    end else if (q_pop) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= q_item.upper;
      win[1][2] <= q_item.lower;
      win[2][2] <= q_item.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  assign krows[0] = kernel_top;
  assign krows[1] = kernel_mid;
  assign krows[2] = kernel_bot;
  assign row_on   = {!s1_flags.row_last, 1'b1, !s1_flags.row_first};
  assign col_on   = {!s1_flags.col_last, 1'b1, !s1_flags.col_first};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_on[r] && col_on[c]) begin
          prd_next[r][c] = $signed({1'b0, win[r][c]}) * $signed(krows[r][8*c +: 8]);
        end else begin
          prd_next[r][c] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_flags <= q_item.flags;
    end
    prd      <= prd_next;
    s2_flags <= s1_flags;
    s3_flags <= s2_flags;
    for (int r = 0; r < 3; r++) begin
      row_sum[r] <= 19'(prd[r][0]) + 19'(prd[r][1]) + 19'(prd[r][2]);
    end
  end

  assign total    = (RES_BITS+1)'(row_sum[0]) + (RES_BITS+1)'(row_sum[1]) +
                    (RES_BITS+1)'(row_sum[2]);
  assign out_push = s3_valid && s3_flags.emit;
  assign out_pop  = pop && !empty;
  assign empty    = (out_count == '0);

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_value[out_wr] <= total[RES_BITS-1:0];
      out_last[out_wr]  <= s3_flags.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      if (out_push) begin
        out_wr <= (out_wr == OAW'(OUT_DEPTH - 1)) ? '0 : out_wr + OAW'(1);
      end
      if (out_pop) begin
        out_rd <= (out_rd == OAW'(OUT_DEPTH - 1)) ? '0 : out_rd + OAW'(1);
      end
      out_count <= out_count + OCW'(out_push) - OCW'(out_pop);
    end
  end

  assign filtered_value = out_value[out_rd];
  assign last_of_image  = out_last[out_rd];

endmodule

// ===== hdl/conv2d_3x3_zero_pad_unit.sv =====
// ----------------------------------------------------------------------------
// conv2d_3x3_zero_pad_unit
// 3x3 convolution with zero padding over a raster stream of 8-bit pixels.
// ----------------------------------------------------------------------------
// Pixels enter through push/full, one item per cycle while full is low. After
// the last pixel of an image the source sends image_width+1 padding items.
// The result for pixel k is produced by item k+image_width+1 and appears on
// filtered_value and last_of_image while empty is low; pop takes it.
// An item's result is registered through the line store stage, the item queue,
// the three-stage multiply-accumulate and the output queue. Throughput: one item
// per cycle while full is low, with line store read and write in the same cycle.
// Items with no result still pass the window so that it keeps sliding.
// When the receiver stalls, up to eight results wait in the output queue;
// the back then stops drawing from the four-entry item queue and full rises.
// A write of image_width or image_height re-derives the row and column of the
// stream position by a serial division, or restarts the image if the position
// lies past the new end; full stays high until that recompute is over.
// Reset restores the default registers and the start of an image; the line
// stores keep their contents and need no clearing.
// ----------------------------------------------------------------------------
`include "conv2d_3x3_zero_pad_unit_assert.svh"

module conv2d_3x3_zero_pad_unit import c3zp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           pixel_in,
  output logic                 empty,
  input  logic                 pop,
  output logic [RES_BITS-1:0]  filtered_value,
  output logic                 last_of_image,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [KROW_BITS-1:0] cfg_data
);

  logic [DIM_BITS-1:0]  image_width;
  logic [DIM_BITS-1:0]  image_height;
  logic [KROW_BITS-1:0] kernel_row_top;
  logic [KROW_BITS-1:0] kernel_row_middle;
  logic [KROW_BITS-1:0] kernel_row_bottom;
  logic                 dim_write;

  c3zp_front_status_t front_status;
  c3zp_item_t         f_item;
  c3zp_item_t         b_item;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic [QCW-1:0]     q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= WIDTH_RESET;
      image_height      <= HEIGHT_RESET;
      kernel_row_top    <= KTOP_RESET;
      kernel_row_middle <= KMID_RESET;
      kernel_row_bottom <= KBOT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width       <= cfg_data[DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height      <= cfg_data[DIM_BITS-1:0];
        CFG_KERNEL_TOP:   kernel_row_top    <= cfg_data;
        CFG_KERNEL_MID:   kernel_row_middle <= cfg_data;
        CFG_KERNEL_BOT:   kernel_row_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front clamps the new sizes in the cycle after the write, once the register holds them.
  assign dim_write = cfg_write &&
                     ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));

  c3zp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .dim_write  (dim_write),
    .width_raw  (image_width),
    .height_raw (image_height),
    .push       (push),
    .pixel_in   (pixel_in),
    .full       (full),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_item     (f_item),
    .status     (front_status)
  );

  c3zp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (f_item),
    .pop       (q_pop),
    .pop_item  (b_item),
    .empty     (q_empty),
    .count     (q_count)
  );

  c3zp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .kernel_top     (kernel_row_top),
    .kernel_mid     (kernel_row_middle),
    .kernel_bot     (kernel_row_bottom),
    .q_empty        (q_empty),
    .q_item         (b_item),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .filtered_value (filtered_value),
    .last_of_image  (last_of_image)
  );

  `C3ZP_ASSERT_NEXT(a_dim_write_blocks, dim_write, full, "size write did not block input")
  `C3ZP_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= QCW'(MQ_DEPTH), "item queue overfilled")
  `C3ZP_ASSERT_NEXT(a_accept_reaches_stage, push && !full, front_status.stage_valid, "item lost")
  `C3ZP_ASSERT_NOW(a_no_accept_busy, push && !full, !front_status.busy, "item taken in recompute")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking regression for the 3x3 zero-padded convolution unit.
// ---------------------------------------------------------------------------
// Pixel items are pushed in bursts with random gaps, while the result side
// pops on a stall pattern that changes over time. A scoreboard class keeps
// its own line stores, sliding window and stream position. It works out the
// filtered value and the end-of-image flag of each result, and compares them
// in order with what the unit returns. Short directed images cover the reset
// kernel, extreme coefficients, saturated and zero sizes, image restarts and
// register changes in mid image. One 1024-wide image and one 1024-tall image
// follow, and then random images of small size.
// ---------------------------------------------------------------------------
module tb_top;
  import c3zp_pkg::*;

  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int END_WAIT_LIMIT = 5000;
  localparam int MAX_REPORTS    = 30;
  localparam logic [2:0] CFG_BEYOND_LIST = CFG_KERNEL_BOT + 3'd1;

  typedef enum {PIX_RANDOM, PIX_WHITE} pixel_fill_e;
  typedef enum {POP_ALWAYS, POP_MOSTLY, POP_RARELY, POP_PERIODIC} pop_style_e;

  typedef struct packed {
    logic [RES_BITS-1:0] value;
    logic                last;
  } conv_result_t;

  class conv_scoreboard;
    logic [DIM_BITS-1:0]  width_reg;
    logic [DIM_BITS-1:0]  height_reg;
    logic [KROW_BITS-1:0] kernel_rows [3];
    logic [7:0]           upper_line [MAX_WIDTH];
    logic [7:0]           lower_line [MAX_WIDTH];
    logic [7:0]           window [3][3];
    int unsigned          position;
    conv_result_t         expected_q [$];
    int unsigned          mismatches;
    int unsigned          results_checked;

    function new();
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      kernel_rows[0] = KTOP_RESET;
      kernel_rows[1] = KMID_RESET;
      kernel_rows[2] = KBOT_RESET;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      foreach (window[r, c]) window[r][c] = '0;
      position = 0;
      mismatches = 0;
      results_checked = 0;
    endfunction

    function int unsigned effective_dim(logic [DIM_BITS-1:0] dim, int unsigned dim_max);
      if (dim == 0) return 1;
      if (dim > dim_max) return dim_max;
      return dim;
    endfunction

    function int unsigned items_left();
      int unsigned w;
      int unsigned total;
      w = effective_dim(width_reg, MAX_WIDTH);
      total = w * effective_dim(height_reg, MAX_HEIGHT) + w + 1;
      return (position >= total) ? total : total - position;
    endfunction

    function void load_register(logic [2:0] idx, logic [KROW_BITS-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg = data[DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_reg = data[DIM_BITS-1:0];
        CFG_KERNEL_TOP:   kernel_rows[0] = data;
        CFG_KERNEL_MID:   kernel_rows[1] = data;
        CFG_KERNEL_BOT:   kernel_rows[2] = data;
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [7:0] pixel);
      int unsigned  w, h, npix, total, p, col, k, krow, kcol;
      int           sum;
      logic [7:0]   up, lo, cur;
      conv_result_t res;
      w = effective_dim(width_reg, MAX_WIDTH);
      h = effective_dim(height_reg, MAX_HEIGHT);
      npix = w * h;
      total = npix + w + 1;
      p = (position >= total) ? 0 : position;
      cur = (p < npix) ? pixel : 8'd0;
      col = p % w;
      up = upper_line[col];
      lo = lower_line[col];
      upper_line[col] = lo;
      lower_line[col] = cur;
      for (int r = 0; r < 3; r++) begin
        window[r][0] = window[r][1];
        window[r][1] = window[r][2];
      end
      window[0][2] = up;
      window[1][2] = lo;
      window[2][2] = cur;
      if (p >= w + 1) begin
        k = p - w - 1;
        krow = k / w;
        kcol = k % w;
        sum = 0;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            if (!((r == 0 && krow == 0) || (r == 2 && krow == h - 1) ||
                  (c == 0 && kcol == 0) || (c == 2 && kcol == w - 1))) begin
              sum += int'(window[r][c]) * int'($signed(kernel_rows[r][8*c +: 8]));
            end
          end
        end
        res.value = sum[RES_BITS-1:0];
        res.last = (k == npix - 1);
        expected_q.push_back(res);
      end
      position = (p + 1 >= total) ? 0 : p + 1;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [RES_BITS-1:0] value, logic last);
      conv_result_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", results_checked));
      end else begin
        want = expected_q.pop_front();
        if (value !== want.value)
          report_mismatch($sformatf("result %0d: filtered_value %0d, expected %0d",
                                    results_checked, $signed(value), $signed(want.value)));
        if (last !== want.last)
          report_mismatch($sformatf("result %0d: last_of_image %b, expected %b",
                                    results_checked, last, want.last));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           pixel_in = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [RES_BITS-1:0]  filtered_value;
  logic                 last_of_image;
  logic                 cfg_write = 1'b0;
  logic [2:0]           cfg_index = CFG_IMAGE_WIDTH;
  logic [KROW_BITS-1:0] cfg_data = '0;

  conv_scoreboard sb;
  int unsigned    items_sent = 0;
  int unsigned    register_writes = 0;
  int unsigned    burst_left = 0;
  bit             sender_idles = 1'b1;
  pop_style_e     pop_mode = POP_ALWAYS;
  int unsigned    pop_phase = 0;
  int unsigned    cycle_count = 0;

  conv2d_3x3_zero_pad_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .pixel_in(pixel_in),
    .empty(empty),
    .pop(pop),
    .filtered_value(filtered_value),
    .last_of_image(last_of_image),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, sb.expected_q.size());
      $display("conv2d_3x3_zero_pad_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_result(filtered_value, last_of_image);
      if (push && !full) sb.note_pixel(pixel_in);
    end
  end

  always @(negedge clk) begin
    if (pop_phase == 0) begin
      pop_mode <= pop_style_e'($urandom_range(0, 3));
      pop_phase <= $urandom_range(16, 96);
    end else begin
      pop_phase <= pop_phase - 1;
    end
    case (pop_mode)
      POP_ALWAYS: pop <= 1'b1;
      POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
      POP_RARELY: pop <= ($urandom_range(0, 3) == 0);
      default:    pop <= (pop_phase % 8 < 3);
    endcase
  end

  function automatic logic [DIM_BITS-1:0] random_dim(int unsigned usual_max,
                                                     int unsigned rare_max);
    case ($urandom_range(0, 9))
      0:       return DIM_BITS'($urandom_range(usual_max + 1, rare_max));
      1:       return '0;
      default: return DIM_BITS'($urandom_range(1, usual_max));
    endcase
  endfunction

  function automatic logic [KROW_BITS-1:0] random_row();
    case ($urandom_range(0, 7))
      0:       return 24'h808080;
      1:       return 24'h7F7F7F;
      default: return KROW_BITS'($urandom());
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] pixel);
    @(negedge clk);
    push <= 1'b1;
    pixel_in <= pixel;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_items(input int unsigned count, input pixel_fill_e fill);
    int unsigned gap;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        gap = (!sender_idles || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          @(negedge clk);
          push <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
        burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      send_pixel((fill == PIX_WHITE) ? 8'hFF : 8'($urandom()));
      items_sent++;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_register(input logic [2:0] idx, input logic [KROW_BITS-1:0] data);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.load_register(idx, data);
    register_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_dim(input logic [2:0] idx, input logic [DIM_BITS-1:0] dim);
    logic [KROW_BITS-1:0] data;
    data = KROW_BITS'($urandom());
    data[DIM_BITS-1:0] = dim;
    program_register(idx, data);
  endtask

  task automatic program_kernel(input logic [KROW_BITS-1:0] top_row,
                                input logic [KROW_BITS-1:0] mid_row,
                                input logic [KROW_BITS-1:0] bot_row);
    program_register(CFG_KERNEL_TOP, top_row);
    program_register(CFG_KERNEL_MID, mid_row);
    program_register(CFG_KERNEL_BOT, bot_row);
  endtask

  initial begin
    logic [2:0]  idx;
    int unsigned cut;
    int unsigned random_start;
    int unsigned waited;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A 2x2 image under the reset kernel is cut short by a smaller height.
    program_dim(CFG_IMAGE_WIDTH, 11'd2);
    program_dim(CFG_IMAGE_HEIGHT, 11'd2);
    send_items(5, PIX_RANDOM);
    wait_drained();
    program_dim(CFG_IMAGE_HEIGHT, 11'd1);
    send_items(sb.items_left(), PIX_RANDOM);
    wait_drained();

    // Full-scale pixels against the most negative, then an all-zero, then the most positive kernel.
    program_dim(CFG_IMAGE_WIDTH, 11'd3);
    program_dim(CFG_IMAGE_HEIGHT, 11'd3);
    program_kernel(24'h808080, 24'h808080, 24'h808080);
    send_items(sb.items_left(), PIX_WHITE);
    wait_drained();
    program_kernel('0, '0, '0);
    send_items(6, PIX_WHITE);
    wait_drained();
    program_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    send_items(sb.items_left(), PIX_WHITE);
    wait_drained();

    // Zero sizes act as one, and writes beyond the register list change nothing.
    program_dim(CFG_IMAGE_WIDTH, '0);
    program_dim(CFG_IMAGE_HEIGHT, '0);
    idx = CFG_BEYOND_LIST;
    repeat (3) begin
      program_register(idx, 24'hFFFFFF);
      idx++;
    end
    program_kernel(random_row(), random_row(), random_row());
    send_items(sb.items_left(), PIX_RANDOM);
    wait_drained();

    sender_idles = 1'b0;
    program_dim(CFG_IMAGE_WIDTH, 11'h7FF);
    program_dim(CFG_IMAGE_HEIGHT, '0);
    send_items(sb.items_left(), PIX_RANDOM);
    wait_drained();
    program_dim(CFG_IMAGE_WIDTH, 11'd1);
    program_dim(CFG_IMAGE_HEIGHT, 11'h7FF);
    send_items(sb.items_left(), PIX_RANDOM);
    wait_drained();
    sender_idles = 1'b1;

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      program_dim(CFG_IMAGE_WIDTH, random_dim(16, 40));
      program_dim(CFG_IMAGE_HEIGHT, random_dim(10, 20));
      program_kernel(random_row(), random_row(), random_row());
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) == 0) begin
          cut = $urandom_range(1, sb.items_left());
          send_items(cut, PIX_RANDOM);
          wait_drained();
          case ($urandom_range(0, 3))
            0:       program_dim(CFG_IMAGE_WIDTH, random_dim(16, 40));
            1:       program_dim(CFG_IMAGE_HEIGHT, random_dim(10, 20));
            2:       program_register(CFG_KERNEL_MID, random_row());
            default: program_register(CFG_BEYOND_LIST + $urandom_range(0, 2),
                                      KROW_BITS'($urandom()));
          endcase
        end
        send_items(sb.items_left(), PIX_RANDOM);
        if ($urandom_range(0, 4) == 0) wait_drained();
      end
      wait_drained();
    end

    @(negedge clk);
    push <= 1'b0;
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived",
                                   sb.expected_q.size()));

    $display("Sent %0d pixel items through %0d register writes; %0d results were checked.",
             items_sent, register_writes, sb.results_checked);
    $display("Images ranged from 1x1 to 1024 wide and 1024 tall, with restarts and "
             , "mid-image register changes.");
    if (sb.mismatches == 0) begin
      $display("conv2d_3x3_zero_pad_unit regression: pass");
    end else begin
      $display("conv2d_3x3_zero_pad_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/c3zp_pkg.sv
hdl/c3zp_div.sv
hdl/c3zp_front.sv
hdl/c3zp_queue.sv
hdl/c3zp_back.sv
hdl/conv2d_3x3_zero_pad_unit.sv
tb/sv/tb_top.sv
